// File: rtl/core/eds_pkg.sv
// Shared types and constants for the executor dispatch scheduler.
package eds_pkg;

  // Default number of node table entries; the scan never looks past SCAN_MAX.
  localparam int NODES_DEF = 16;
  localparam int SCAN_MAX  = 16;

  // Configuration port.
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IO_THREADS = 1'b1;

  localparam logic [4:0]  NODE_COUNT_RST = 5'd0;
  localparam logic [6:0]  IO_THREADS_RST = 7'd1;
  localparam logic [6:0]  THREAD_MAX     = 7'd64;
  localparam logic [31:0] RNG_SEED       = 32'd1;

  // Item function codes.
  localparam logic FUNC_UPDATE   = 1'b0;
  localparam logic FUNC_DISPATCH = 1'b1;

  typedef struct packed {
    logic       func;
    logic [3:0] node_index;
    logic [7:0] free_executors;
    logic [7:0] request_count;
    logic       source_valid;
    logic [3:0] source_node;
    logic       wants_reply;
  } in_item_t;

  typedef struct packed {
    logic [3:0] target_node;
    logic [7:0] assigned_count;
    logic [5:0] io_thread;
    logic       failed;
    logic       last;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic scan_step;
    logic set_single;
    logic rng_node;
    logic set_pick;
    logic rng_thread;
    logic deal_step;
    logic seek_clr;
    logic seek_step;
    logic set_batch;
    logic emit_ok;
    logic emit_fail;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic scan_done;
    logic req_gt1;
    logic max_ge_req;
    logic total_ge_req;
    logic max_nz;
    logic nodes_nz;
    logic reply;
    logic deal_done;
    logic mod_done;
    logic emit_hit;
    logic last;
  } dp_sts_t;

endpackage

// File: rtl/core/eds_mod.sv
// Multi-cycle 32-bit by 7-bit remainder unit, four dividend bits per cycle.
module eds_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [6:0]  divisor,
  output logic        done,
  output logic [6:0]  result
);

  localparam int BITS_PER_STEP = 4;
  localparam int STEPS         = 32 / BITS_PER_STEP;
  localparam int CNT_W         = $clog2(STEPS);

  logic [31:0]      dvd_r;
  logic [6:0]       dsr_r;
  logic [6:0]       rem_r;
  logic [6:0]       rem_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             act_r;
  logic             done_r;

  // Restoring steps: remainder stays below the divisor, so 8 bits cover a shift.
  always_comb begin
    logic [7:0] acc;
    acc = {1'b0, rem_r};
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      acc = {acc[6:0], dvd_r[31-k]};
      if (acc >= {1'b0, dsr_r}) begin
        acc = acc - {1'b0, dsr_r};
      end
    end
    rem_nxt = acc[6:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        act_r <= 1'b1;
        cnt_r <= '0;
      end else if (act_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (act_r) begin
      dvd_r <= {dvd_r[31-BITS_PER_STEP:0], {BITS_PER_STEP{1'b0}}};
      rem_r <= rem_nxt;
    end
  end

  assign done   = done_r;
  assign result = rem_r;

endmodule

// File: rtl/core/eds_dp.sv
// Datapath: node table, scan accumulators, dealing counters, random word, result register.
module eds_dp #(
  parameter int NODES = eds_pkg::NODES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  eds_pkg::in_item_t                  in_item,
  input  logic                               cfg_we,
  input  logic [eds_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [eds_pkg::CFG_W-1:0]          cfg_wdata,
  input  eds_pkg::dp_cmd_t                   cmd,
  output eds_pkg::dp_sts_t                   sts,
  output logic                               out_strobe,
  output eds_pkg::out_item_t                 out_item
);

  localparam int TBL   = (NODES < eds_pkg::SCAN_MAX) ? NODES : eds_pkg::SCAN_MAX;
  localparam int IW    = (TBL > 1) ? $clog2(TBL) : 1;
  localparam int CNT_W = $clog2(TBL + 1);

  function automatic logic [31:0] xorshift(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  // Configuration and persistent state.
  logic [4:0]  node_count_r;
  logic [6:0]  io_threads_r;
  logic [31:0] rng_r;
  logic [31:0] rng_nxt;
  logic [7:0]  table_r [TBL];

  // Latched dispatch item.
  logic [7:0]  req_r;
  logic        src_on_r;
  logic [3:0]  src_r;
  logic        reply_r;

  // Scan and dealing state.
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] ptr_r;
  logic [7:0]       dealt_r;
  logic [7:0]       max_r;
  logic [IW-1:0]    max_idx_r;
  logic [11:0]      total_r;
  logic [7:0]       rem_r  [TBL];
  logic [7:0]       load_r [TBL];

  // Pending result.
  logic [3:0] tgt_r;
  logic [7:0] cnt_r;
  logic       last_r;
  logic       out_strobe_r;
  eds_pkg::out_item_t out_r;

  logic [CNT_W-1:0] n_eff;
  logic [6:0]       thr_eff;
  logic [6:0]       mod_dsr;
  logic             mod_start;
  logic             mod_done;
  logic [6:0]       mod_res;
  logic [7:0]       cur_f;
  logic             cur_excl;
  logic [IW-1:0]    deal_j;
  logic             any_above;

  assign n_eff   = (node_count_r > 5'(TBL)) ? CNT_W'(TBL) : CNT_W'(node_count_r);
  assign thr_eff = (io_threads_r > eds_pkg::THREAD_MAX) ? eds_pkg::THREAD_MAX : io_threads_r;
  assign rng_nxt = xorshift(rng_r);

  assign cur_f    = table_r[idx_r[IW-1:0]];
  assign cur_excl = src_on_r && (int'(src_r) == int'(idx_r));

  // Next node with free executors left, searching cyclically from the deal pointer.
  always_comb begin
    logic [IW-1:0] hi_j;
    logic [IW-1:0] lo_j;
    logic          hi_found;
    hi_j     = '0;
    lo_j     = '0;
    hi_found = 1'b0;
    for (int i = TBL - 1; i >= 0; i--) begin
      if (rem_r[i] != 8'd0) begin
        lo_j = IW'(i);
        if (i >= int'(ptr_r)) begin
          hi_j     = IW'(i);
          hi_found = 1'b1;
        end
      end
    end
    deal_j = hi_found ? hi_j : lo_j;
  end

  // Any loaded node beyond the seek pointer.
  always_comb begin
    any_above = 1'b0;
    for (int i = 0; i < TBL; i++) begin
      if (i > int'(idx_r) && load_r[i] != 8'd0) begin
        any_above = 1'b1;
      end
    end
  end

  assign mod_start = cmd.rng_node || cmd.rng_thread;
  assign mod_dsr   = cmd.rng_node ? 7'(n_eff) :
                     ((thr_eff == 7'd0) ? 7'd1 : thr_eff);

  eds_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (rng_nxt),
    .divisor  (mod_dsr),
    .done     (mod_done),
    .result   (mod_res)
  );

  // Control state, configuration, node table and random word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= eds_pkg::NODE_COUNT_RST;
      io_threads_r <= eds_pkg::IO_THREADS_RST;
      rng_r        <= eds_pkg::RNG_SEED;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < TBL; i++) begin
        table_r[i] <= 8'd0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          eds_pkg::CFG_NODE_COUNT: node_count_r <= cfg_wdata[4:0];
          eds_pkg::CFG_IO_THREADS: io_threads_r <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (cmd.accept && in_item.func == eds_pkg::FUNC_UPDATE &&
          {1'b0, in_item.node_index} < 5'(TBL)) begin
        table_r[in_item.node_index[IW-1:0]] <= in_item.free_executors;
      end
      if (mod_start) begin
        rng_r <= rng_nxt;
      end
      out_strobe_r <= cmd.emit_ok || cmd.emit_fail;
    end
  end

  // Per-dispatch working registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r    <= in_item.request_count;
      src_on_r <= in_item.source_valid;
      src_r    <= in_item.source_node;
      reply_r  <= in_item.wants_reply;
      idx_r    <= '0;
      ptr_r    <= '0;
      dealt_r  <= 8'd0;
      max_r    <= 8'd0;
      max_idx_r <= '0;
      total_r  <= 12'd0;
      for (int i = 0; i < TBL; i++) begin
        rem_r[i]  <= 8'd0;
        load_r[i] <= 8'd0;
      end
    end
    if (cmd.scan_step) begin
      idx_r <= idx_r + 1'b1;
      if (!cur_excl) begin
        total_r <= total_r + 12'(cur_f);
        rem_r[idx_r[IW-1:0]] <= cur_f;
        if (cur_f > max_r) begin
          max_r     <= cur_f;
          max_idx_r <= idx_r[IW-1:0];
        end
      end
    end
    if (cmd.deal_step) begin
      load_r[deal_j] <= load_r[deal_j] + 8'd1;
      rem_r[deal_j]  <= rem_r[deal_j] - 8'd1;
      ptr_r          <= CNT_W'(deal_j) + 1'b1;
      dealt_r        <= dealt_r + 8'd1;
    end
    if (cmd.seek_clr) begin
      idx_r <= '0;
    end
    if (cmd.seek_step || cmd.set_batch) begin
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.set_single) begin
      tgt_r  <= 4'(max_idx_r);
      cnt_r  <= req_r;
      last_r <= 1'b1;
    end
    if (cmd.set_pick) begin
      tgt_r  <= mod_res[3:0];
      cnt_r  <= req_r;
      last_r <= 1'b1;
    end
    if (cmd.set_batch) begin
      tgt_r  <= 4'(idx_r);
      cnt_r  <= load_r[idx_r[IW-1:0]];
      last_r <= !any_above;
    end
    if (cmd.emit_ok) begin
      out_r.target_node    <= tgt_r;
      out_r.assigned_count <= cnt_r;
      out_r.io_thread      <= (thr_eff == 7'd0) ? 6'd0 : mod_res[5:0];
      out_r.failed         <= 1'b0;
      out_r.last           <= last_r;
    end
    if (cmd.emit_fail) begin
      out_r.target_node    <= 4'd0;
      out_r.assigned_count <= 8'd0;
      out_r.io_thread      <= 6'd0;
      out_r.failed         <= 1'b1;
      out_r.last           <= 1'b1;
    end
  end

  always_comb begin
    sts.scan_done    = (idx_r >= n_eff);
    sts.req_gt1      = (req_r > 8'd1);
    sts.max_ge_req   = (max_r >= req_r);
    sts.total_ge_req = (total_r >= {4'd0, req_r});
    sts.max_nz       = (max_r != 8'd0);
    sts.nodes_nz     = (n_eff != '0);
    sts.reply        = reply_r;
    sts.deal_done    = (dealt_r == req_r);
    sts.mod_done     = mod_done;
    sts.emit_hit     = (load_r[idx_r[IW-1:0]] != 8'd0);
    sts.last         = last_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

// File: rtl/core/eds_ctrl.sv
// Controller: sequences scan, decision, dealing and result emission.
module eds_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_func,
  input  eds_pkg::dp_sts_t sts,
  output eds_pkg::dp_cmd_t cmd,
  output logic             busy
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_SCAN   = 8'b0000_0010,
    ST_DECIDE = 8'b0000_0100,
    ST_PMOD   = 8'b0000_1000,
    ST_DRAW   = 8'b0001_0000,
    ST_TMOD   = 8'b0010_0000,
    ST_DEAL   = 8'b0100_0000,
    ST_SEEK   = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (in_func == eds_pkg::FUNC_DISPATCH) begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_DECIDE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_DECIDE: begin
        if (sts.req_gt1) begin
          if (sts.max_ge_req) begin
            cmd.set_single = 1'b1;
            state_nxt      = ST_DRAW;
          end else if (sts.total_ge_req) begin
            state_nxt = ST_DEAL;
          end else begin
            cmd.emit_fail = sts.reply;
            state_nxt     = ST_IDLE;
          end
        end else begin
          if (sts.max_nz) begin
            cmd.set_single = 1'b1;
            state_nxt      = ST_DRAW;
          end else if (sts.nodes_nz) begin
            cmd.rng_node = 1'b1;
            state_nxt    = ST_PMOD;
          end else begin
            cmd.emit_fail = sts.reply;
            state_nxt     = ST_IDLE;
          end
        end
      end
      ST_PMOD: begin
        if (sts.mod_done) begin
          cmd.set_pick = 1'b1;
          state_nxt    = ST_DRAW;
        end
      end
      ST_DRAW: begin
        cmd.rng_thread = 1'b1;
        state_nxt      = ST_TMOD;
      end
      ST_TMOD: begin
        if (sts.mod_done) begin
          cmd.emit_ok = 1'b1;
          state_nxt   = sts.last ? ST_IDLE : ST_SEEK;
        end
      end
      ST_DEAL: begin
        if (sts.deal_done) begin
          cmd.seek_clr = 1'b1;
          state_nxt    = ST_SEEK;
        end else begin
          cmd.deal_step = 1'b1;
        end
      end
      ST_SEEK: begin
        if (sts.emit_hit) begin
          cmd.set_batch = 1'b1;
          state_nxt     = ST_DRAW;
        end else begin
          cmd.seek_step = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

// File: rtl/core/executor_dispatch_scheduler_top.sv
// Top level of the executor dispatch scheduler: controller plus datapath.
//
// Usage: drive in_item and pulse start while busy is low; the item is taken
// at that edge. func update writes one entry of the free executor table in
// that same cycle and busy stays low. func dispatch raises busy until the
// last result beat has been issued. Each result beat shows on out_item for
// one cycle with out_strobe high; out_item.last marks the final beat of a
// dispatch. A failed dispatch gives one beat with failed set, or none when
// no reply is wanted. The receiver cannot stall: every beat must be taken.
// Configuration (cfg_we, cfg_idx, cfg_wdata) must be written while busy
// is low; the block itself does not enforce this. Each dispatch, with n =
// configured nodes, runs accept, a scan of the n table entries plus a step
// to see the end, and a decision. A single result then takes a draw and a
// pass through the remainder unit (8 steps of 4 bits); a random node pick
// adds another pass. A batch deals one request per cycle, then walks the
// nodes one per cycle, pausing at each node with a share for its beat.
// Reset clears the table, sets the random word to 1, node_count to 0 and
// io_threads to 1; no clearing pass is needed.
module executor_dispatch_scheduler_top #(
  parameter int NODES = eds_pkg::NODES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  eds_pkg::in_item_t              in_item,
  output logic                           out_strobe,
  output eds_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [eds_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [eds_pkg::CFG_W-1:0]      cfg_wdata
);

  eds_pkg::dp_cmd_t cmd;
  eds_pkg::dp_sts_t sts;

  // Sequence each dispatch; hold busy while any work is pending.
  eds_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_func (in_item.func),
    .sts     (sts),
    .cmd     (cmd),
    .busy    (busy)
  );

  // Table, scan accumulators, dealing counters and the result register.
  eds_dp #(
    .NODES (NODES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// File: dv/executor_dispatch_scheduler_top_tb.sv
// Self-checking testbench for executor_dispatch_scheduler_top.
module executor_dispatch_scheduler_top_tb;
  import eds_pkg::*;

  // Table depth matches the default build of the block.
  localparam int TABLE_DEPTH   = NODES_DEF;
  // Quiet cycles required before a register write or the final verdict.
  // A dispatch that ends without a beat still runs accept, scan and decide.
  localparam int SETTLE_CYCLES = 48;
  // The worst item is a 255-request deal with 16 result beats and a long
  // sender gap. Allow several times the full run.
  localparam int CYCLE_LIMIT   = 800000;
  localparam int PHASES        = 9;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  in_item_t             in_item   = '0;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx   = CFG_NODE_COUNT;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Shadow of the scheduler state, advanced item by item as items are taken.
  logic [7:0]           free_table [TABLE_DEPTH];
  logic [31:0]          rng_word;
  logic [4:0]           nodes_cfg;
  logic [6:0]           threads_cfg;

  in_item_t             send_queue [$];
  out_item_t            planned_beats [$];
  out_item_t            beat_want;
  int unsigned          gap_left    = 0;
  bit                   gapless     = 1'b0;
  int                   error_count = 0;
  int unsigned          cycle_count = 0;

  executor_dispatch_scheduler_top #(.NODES(TABLE_DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow scheduler
  // ---------------------------------------------------------------------------

  // Advance the 32-bit xorshift word and return the new value.
  function automatic logic [31:0] next_random();
    logic [31:0] x;
    x = rng_word;
    x ^= x << 13;
    x ^= x >> 17;
    x ^= x << 5;
    rng_word = x;
    return x;
  endfunction

  // Draw an I/O thread; the draw happens even when the thread count is zero.
  function automatic logic [5:0] pick_thread();
    logic [31:0] r;
    int unsigned t;
    r = next_random();
    t = (threads_cfg > THREAD_MAX) ? THREAD_MAX : threads_cfg;
    if (t == 0) return '0;
    return 6'(r % t);
  endfunction

  function automatic out_item_t share_beat(int unsigned node, int unsigned count);
    out_item_t b;
    b = '0;
    b.target_node    = 4'(node);
    b.assigned_count = 8'(count);
    return b;
  endfunction

  // Work out every beat one dispatch call produces and queue them in order.
  task automatic plan_dispatch(input in_item_t item);
    int unsigned n, req, max_val, max_idx, total, navail, pos, i;
    int unsigned avail_idx [16];
    int unsigned rem [16];
    int unsigned share [16];
    out_item_t   beats [$];
    out_item_t   b;
    n = nodes_cfg;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    if (n > SCAN_MAX) n = SCAN_MAX;
    req     = item.request_count;
    max_val = 0;
    max_idx = 0;
    total   = 0;
    navail  = 0;

    // Scan configured nodes, skip the source, keep the first largest.
    for (i = 0; i < n; i++) begin
      if (item.source_valid && item.source_node == i) continue;
      if (free_table[i] != 0) begin
        total            += free_table[i];
        avail_idx[navail] = i;
        rem[navail]       = free_table[i];
        share[navail]     = 0;
        navail++;
      end
      if (free_table[i] > max_val) begin
        max_val = free_table[i];
        max_idx = i;
      end
    end

    if (req > 1) begin
      if (max_val >= req) begin
        beats = {beats, share_beat(max_idx, req)};
      end else if (total >= req && navail > 0) begin
        // Deal one request at a time, round-robin over nodes with room left.
        pos = 0;
        repeat (req) begin
          while (rem[pos] == 0) pos = (pos + 1) % navail;
          share[pos]++;
          rem[pos]--;
          pos = (pos + 1) % navail;
        end
        for (i = 0; i < navail; i++)
          if (share[i] != 0) beats = {beats, share_beat(avail_idx[i], share[i])};
      end
    end else if (max_val > 0) begin
      beats = {beats, share_beat(max_idx, req)};
    end else if (n > 0) begin
      // Nothing free: any configured node, the source included.
      beats = {beats, share_beat(next_random() % n, req)};
    end

    // Thread draws follow the node draw, one per beat in beat order.
    foreach (beats[k]) beats[k].io_thread = pick_thread();

    if (beats.size() == 0 && item.wants_reply) begin
      b        = '0;
      b.failed = 1'b1;
      beats    = {beats, b};
    end
    if (beats.size() != 0) beats[beats.size() - 1].last = 1'b1;
    planned_beats = {planned_beats, beats};
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Append one item to the sender's backlog.
  function automatic void add_item(input in_item_t it);
    send_queue = {send_queue, it};
  endfunction

  function automatic in_item_t make_update(int unsigned idx, int unsigned val);
    in_item_t it;
    it                = '0;
    it.func           = FUNC_UPDATE;
    it.node_index     = 4'(idx);
    it.free_executors = 8'(val);
    return it;
  endfunction

  function automatic in_item_t make_call(int unsigned req, bit src_on, int unsigned src,
                                         bit reply);
    in_item_t it;
    it               = '0;
    it.func          = FUNC_DISPATCH;
    it.request_count = 8'(req);
    it.source_valid  = src_on;
    it.source_node   = 4'(src);
    it.wants_reply   = reply;
    return it;
  endfunction

  // Random item: unused fields stay random so every bit toggles. Free counts
  // lean small and request counts lean moderate so the round-robin deal and
  // the failure path both get plenty of traffic.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned roll, n;
    n = (nodes_cfg > TABLE_DEPTH) ? TABLE_DEPTH : nodes_cfg;
    it.node_index     = 4'($urandom_range(0, 15));
    it.free_executors = 8'($urandom_range(0, 255));
    it.request_count  = 8'($urandom_range(0, 255));
    it.source_valid   = 1'($urandom_range(0, 1));
    it.source_node    = 4'($urandom_range(0, 15));
    it.wants_reply    = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 40) begin
      it.func = FUNC_UPDATE;
      if (n != 0 && $urandom_range(0, 3) != 0) it.node_index = 4'($urandom_range(0, n - 1));
      roll = $urandom_range(0, 99);
      if (roll < 20) it.free_executors = 8'd0;
      else if (roll < 75) it.free_executors = 8'($urandom_range(1, 12));
      else if (roll < 85) it.free_executors = 8'd255;
    end else begin
      it.func = FUNC_DISPATCH;
      roll = $urandom_range(0, 99);
      if (roll < 25) it.request_count = 8'($urandom_range(0, 1));
      else if (roll < 70) it.request_count = 8'($urandom_range(2, 40));
      else if (roll >= 90) it.request_count = 8'd255;
      if (n != 0 && $urandom_range(0, 1) != 0) it.source_node = 4'($urandom_range(0, n - 1));
    end
    return it;
  endfunction

  // Mostly back to back (always, when gapless is set), some short gaps, a few long ones.
  function automatic int unsigned draw_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (gapless || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive one register write; the shadow takes the value as the write is driven, before the block registers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    if (idx == CFG_NODE_COUNT) nodes_cfg = value[4:0];
    else threads_cfg = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until the sender is empty, every planned beat has arrived and the
  // block has been idle for a full settle window.
  task automatic wait_idle();
    int unsigned quiet;
    quiet = 0;
    while (quiet < SETTLE_CYCLES) begin
      @(negedge clk);
      if (send_queue.size() == 0 && !start && !busy && planned_beats.size() == 0)
        quiet++;
      else
        quiet = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: take pending items from send_queue, hold each until accepted.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start    <= 1'b0;
      gap_left <= 0;
    end else begin
      // The item on the port is taken at this edge: advance the shadow.
      if (start && !busy) begin
        if (in_item.func == FUNC_UPDATE) free_table[in_item.node_index] = in_item.free_executors;
        else plan_dispatch(in_item);
      end
      if (start && busy) begin
        // Hold the current item until the block frees up.
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (send_queue.size() != 0) begin
        in_item  <= send_queue.pop_front();
        start    <= 1'b1;
        gap_left <= draw_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed beat must match the oldest planned beat.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) begin
      if (planned_beats.size() == 0) begin
        $error("unplanned result beat: target_node %0d assigned_count %0d failed %0b",
               out_item.target_node, out_item.assigned_count, out_item.failed);
        error_count++;
      end else begin
        beat_want = planned_beats.pop_front();
        if (out_item.target_node !== beat_want.target_node) begin
          $error("target_node: expected %0d, got %0d", beat_want.target_node,
                 out_item.target_node);
          error_count++;
        end
        if (out_item.assigned_count !== beat_want.assigned_count) begin
          $error("assigned_count: expected %0d, got %0d", beat_want.assigned_count,
                 out_item.assigned_count);
          error_count++;
        end
        if (out_item.io_thread !== beat_want.io_thread) begin
          $error("io_thread: expected %0d, got %0d", beat_want.io_thread, out_item.io_thread);
          error_count++;
        end
        if (out_item.failed !== beat_want.failed) begin
          $error("failed: expected %0b, got %0b", beat_want.failed, out_item.failed);
          error_count++;
        end
        if (out_item.last !== beat_want.last) begin
          $error("last: expected %0b, got %0b", beat_want.last, out_item.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("run did not drain within %0d cycles", CYCLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed checks, then random phases under several
  // register settings. Registers change only while the block is idle.
  // ---------------------------------------------------------------------------
  int unsigned phase_nodes   [PHASES] = '{16, 31, 3, 16, 1, 0, 100, 0, 0};
  int unsigned phase_threads [PHASES] = '{1, 0, 127, 64, 7, 64, 33, 0, 0};

  initial begin
    foreach (free_table[i]) free_table[i] = '0;
    rng_word    = RNG_SEED;
    nodes_cfg   = NODE_COUNT_RST;
    threads_cfg = IO_THREADS_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: no nodes configured, so every call fails.
    add_item(make_call(1, 0, 0, 1));
    add_item(make_call(0, 0, 0, 0));
    add_item(make_update(15, 255));
    add_item(make_call(3, 0, 0, 1));
    wait_idle();

    // Four nodes, full thread range.
    write_reg(CFG_NODE_COUNT, 7'd4);
    write_reg(CFG_IO_THREADS, 7'd64);
    add_item(make_update(0, 3));
    add_item(make_update(1, 7));
    add_item(make_update(2, 7));
    add_item(make_update(3, 0));
    add_item(make_call(7, 0, 0, 0));     // first largest takes all
    add_item(make_call(7, 1, 1, 0));     // source skipped, next largest
    add_item(make_call(12, 0, 0, 1));    // round-robin deal
    add_item(make_call(17, 0, 0, 1));    // total exactly enough
    add_item(make_call(18, 0, 0, 1));    // short by one: error beat
    add_item(make_call(0, 0, 0, 0));     // zero requests
    add_item(make_call(1, 1, 1, 0));     // single, source skipped
    add_item(make_call(2, 1, 9, 0));     // source beyond configured nodes
    add_item(make_call(255, 0, 0, 1));   // far too many
    add_item(make_update(0, 0));
    add_item(make_update(1, 0));
    add_item(make_update(2, 0));
    add_item(make_call(1, 0, 0, 0));     // nothing free: random node
    add_item(make_call(0, 1, 2, 1));     // random node may hit source
    add_item(make_update(3, 255));
    add_item(make_call(255, 1, 3, 1));   // only capacity is the source
    add_item(make_call(255, 0, 0, 1));   // single node takes the max
    wait_idle();

    // Random phases; the last two pick their own register values.
    for (int p = 0; p < PHASES; p++) begin
      gapless = (p == 1 || p == 4);
      if (p >= 7) begin
        phase_nodes[p]   = $urandom_range(0, 31);
        phase_threads[p] = $urandom_range(0, 127);
      end
      write_reg(CFG_NODE_COUNT, 7'(phase_nodes[p]));
      write_reg(CFG_IO_THREADS, 7'(phase_threads[p]));
      repeat ((phase_nodes[p] == 0) ? 10 : 25) add_item(random_item());
      wait_idle();
    end

    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
